/* rtl/sd72_pkg.sv */
package sd72_pkg;

	localparam int DATA_W = 64;
	localparam int CHK_W = 8;
	localparam int CW_N = DATA_W + CHK_W;
	localparam int BYTE_N = DATA_W / 8;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CHK_W-1:0] chk_t;
	typedef logic [1:0] status_t;
	typedef logic [CW_N-1:0] hit_t;

	// result status codes
	localparam status_t ST_CLEAN = 2'd0;
	localparam status_t ST_DATA = 2'd1;
	localparam status_t ST_CHECK = 2'd2;
	localparam status_t ST_UNCORR = 2'd3;

	// parity-check rows over the data; row i also covers check bit 7-i
	localparam data_t ROW_MASK [CHK_W] = '{
		64'hFF0F0F0C_68888880,
		64'hF0FF00F3_64444440,
		64'h30F0FF0F_02222226,
		64'hCF00F0FF_01111116,
		64'h68888880_FF0F00F3,
		64'h64444440_F0FF0F0C,
		64'h02222226_CF00FF0F,
		64'h01111116_30F0F0FF
	};

	// single-error syndromes: 0..63 data bit n, 64..71 check bit n-64
	localparam chk_t SINGLE_SYN [CW_N] = '{
		8'h0b, 8'h3b, 8'h37, 8'h07, 8'h19, 8'h29, 8'h49, 8'h89,
		8'h16, 8'h26, 8'h46, 8'h86, 8'h13, 8'h23, 8'h43, 8'h83,
		8'h1c, 8'h2c, 8'h4c, 8'h8c, 8'h15, 8'h25, 8'h45, 8'h85,
		8'h1a, 8'h2a, 8'h4a, 8'h8a, 8'h0d, 8'hcd, 8'hce, 8'h0e,
		8'h70, 8'h73, 8'hb3, 8'hb0, 8'h51, 8'h52, 8'h54, 8'h58,
		8'ha1, 8'ha2, 8'ha4, 8'ha8, 8'h31, 8'h32, 8'h34, 8'h38,
		8'hc1, 8'hc2, 8'hc4, 8'hc8, 8'h61, 8'h62, 8'h64, 8'h68,
		8'h91, 8'h92, 8'h94, 8'h98, 8'he0, 8'hec, 8'hdc, 8'hd0,
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
	};

endpackage

/* rtl/sd72_syn.sv */
module sd72_syn (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sd72_pkg::chk_t   chk,
	input  sd72_pkg::data_t  data,
	output logic             out_valid,
	input  logic             out_ready,
	output sd72_pkg::chk_t   syn,
	output sd72_pkg::data_t  data_out
);

	logic                                       vld_s1, vld_s2;
	logic                                       rdy_s1, rdy_s2;
	logic [sd72_pkg::BYTE_N-1:0]                part_s1 [sd72_pkg::CHK_W];
	logic [sd72_pkg::BYTE_N-1:0]                part_c [sd72_pkg::CHK_W];
	sd72_pkg::chk_t                             chk_s1;
	sd72_pkg::data_t                            data_s1;
	sd72_pkg::chk_t                             syn_c;
	sd72_pkg::chk_t                             syn_s2;
	sd72_pkg::data_t                            data_s2;

	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign rdy_s2 = !vld_s2 || out_ready;
	assign in_ready = rdy_s1;

	// per-byte parities of each row
	always_comb begin
		for (int i = 0; i < sd72_pkg::CHK_W; i++) begin
			for (int j = 0; j < sd72_pkg::BYTE_N; j++) begin
				part_c[i][j] = ^(data[j*8 +: 8] & sd72_pkg::ROW_MASK[i][j*8 +: 8]);
			end
		end
	end

	// fold byte parities with the check bit of each row
	always_comb begin
		for (int i = 0; i < sd72_pkg::CHK_W; i++) begin
			syn_c[sd72_pkg::CHK_W-1-i] = (^part_s1[i]) ^ chk_s1[sd72_pkg::CHK_W-1-i];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			part_s1 <= part_c;
			chk_s1 <= chk;
			data_s1 <= data;
		end
		if (vld_s1 && rdy_s2) begin
			syn_s2 <= syn_c;
			data_s2 <= data_s1;
		end
	end

	assign out_valid = vld_s2;
	assign syn = syn_s2;
	assign data_out = data_s2;

endmodule

/* rtl/sd72_match.sv */
module sd72_match (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sd72_pkg::chk_t   syn,
	input  sd72_pkg::data_t  data,
	output logic             out_valid,
	input  logic             out_ready,
	output sd72_pkg::hit_t   hit,
	output sd72_pkg::chk_t   syn_out,
	output sd72_pkg::data_t  data_out
);

	logic             vld_s3;
	sd72_pkg::hit_t   hit_c;
	sd72_pkg::hit_t   hit_s3;
	sd72_pkg::chk_t   syn_s3;
	sd72_pkg::data_t  data_s3;

	assign in_ready = !vld_s3 || out_ready;

	// compare against every single-error syndrome
	always_comb begin
		for (int n = 0; n < sd72_pkg::CW_N; n++) begin
			hit_c[n] = (syn == sd72_pkg::SINGLE_SYN[n]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hit_s3 <= hit_c;
			syn_s3 <= syn;
			data_s3 <= data;
		end
	end

	assign out_valid = vld_s3;
	assign hit = hit_s3;
	assign syn_out = syn_s3;
	assign data_out = data_s3;

endmodule

/* rtl/sd72_fix.sv */
module sd72_fix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sd72_pkg::hit_t     hit,
	input  sd72_pkg::chk_t     syn,
	input  sd72_pkg::data_t    data,
	output logic               out_valid,
	input  logic               out_ready,
	output sd72_pkg::data_t    data_out,
	output sd72_pkg::chk_t     syn_out,
	output sd72_pkg::status_t  status
);

	logic               vld_s4;
	sd72_pkg::hit_t     low_c;
	sd72_pkg::status_t  status_c;
	sd72_pkg::data_t    data_s4;
	sd72_pkg::chk_t     syn_s4;
	sd72_pkg::status_t  status_s4;

	assign in_ready = !vld_s4 || out_ready;

	// lowest matching position wins
	assign low_c = hit & (~hit + sd72_pkg::hit_t'(1));

	// classify the syndrome
	always_comb begin
		if (syn == '0) begin
			status_c = sd72_pkg::ST_CLEAN;
		end else if (hit == '0) begin
			status_c = sd72_pkg::ST_UNCORR;
		end else if (|low_c[sd72_pkg::DATA_W-1:0]) begin
			status_c = sd72_pkg::ST_DATA;
		end else begin
			status_c = sd72_pkg::ST_CHECK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (in_ready) begin
			vld_s4 <= in_valid;
		end
	end

	// flip the data bit of a single data error
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s4 <= data ^ low_c[sd72_pkg::DATA_W-1:0];
			syn_s4 <= syn;
			status_s4 <= status_c;
		end
	end

	assign out_valid = vld_s4;
	assign data_out = data_s4;
	assign syn_out = syn_s4;
	assign status = status_s4;

endmodule

/* rtl/secded_72_64_decoder.sv */
// path: registered through stages s1 and s2 (syndrome), s3 (match) and s4 (fix)
// throughput: one codeword per cycle while result_ready is high; each of the
// four register stages holds while its successor is full and stalled
// reset: arst_n clears all stage valid bits asynchronously; data registers
// are not reset
module secded_72_64_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_ready,
	input  sd72_pkg::chk_t     check_bits,
	input  sd72_pkg::data_t    received_data,
	output logic               result_valid,
	input  logic               result_ready,
	output sd72_pkg::data_t    corrected_data,
	output sd72_pkg::chk_t     syndrome,
	output sd72_pkg::status_t  status
);

	logic             syn_valid, syn_ready;
	sd72_pkg::chk_t   syn_a;
	sd72_pkg::data_t  data_a;
	logic             hit_valid, hit_ready;
	sd72_pkg::hit_t   hit_b;
	sd72_pkg::chk_t   syn_b;
	sd72_pkg::data_t  data_b;

	// syndrome trees, two stages
	sd72_syn u_syn (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (data_valid),
		.in_ready  (data_ready),
		.chk       (check_bits),
		.data      (received_data),
		.out_valid (syn_valid),
		.out_ready (syn_ready),
		.syn       (syn_a),
		.data_out  (data_a)
	);

	// single-error syndrome compare
	sd72_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (syn_valid),
		.in_ready  (syn_ready),
		.syn       (syn_a),
		.data      (data_a),
		.out_valid (hit_valid),
		.out_ready (hit_ready),
		.hit       (hit_b),
		.syn_out   (syn_b),
		.data_out  (data_b)
	);

	// correction and status, output register
	sd72_fix u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hit_valid),
		.in_ready  (hit_ready),
		.hit       (hit_b),
		.syn       (syn_b),
		.data      (data_b),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.data_out  (corrected_data),
		.syn_out   (syndrome),
		.status    (status)
	);

endmodule

/* rtl/sd72_checker.sv */
module sd72_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	input  logic               data_ready,
	input  sd72_pkg::chk_t     check_bits,
	input  sd72_pkg::data_t    received_data,
	input  logic               result_valid,
	input  logic               result_ready,
	input  sd72_pkg::data_t    corrected_data,
	input  sd72_pkg::chk_t     syndrome,
	input  sd72_pkg::status_t  status
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(corrected_data)
			&& $stable(syndrome) && $stable(status))
		else $error("stalled result changed");

	// clean exactly when the syndrome is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((status == sd72_pkg::ST_CLEAN) == (syndrome == '0)))
		else $error("clean status does not match zero syndrome");

	// check bit errors have single-bit syndromes
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == sd72_pkg::ST_CHECK |-> $onehot(syndrome))
		else $error("check bit error with non-unit syndrome");

	// data corrections come from odd syndromes of weight three or more
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == sd72_pkg::ST_DATA |->
			$countones(syndrome) >= 3 && syndrome[0] ^ (^syndrome[7:1]))
		else $error("data correction with wrong syndrome weight");

endmodule

bind secded_72_64_decoder sd72_checker u_chk (.*);
